### rtl/core/gob_pkg.sv
// ----------------------------------------------------------------------------
// Gradient orientation binner package
// Shared widths, register indexes, CORDIC angle table and result word type.
// ----------------------------------------------------------------------------
package gob_pkg;

  localparam int MaxWidth   = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int MaxBins    = 32;
  localparam int CordicSteps = 20;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_BINS   = 3'd3;
  localparam logic [2:0] REG_NOISE  = 3'd4;

  typedef struct packed {
    logic [9:0]  col;
    logic [11:0] row;
    logic [15:0] magnitude;
    logic [15:0] direction;
    logic [4:0]  bin_low;
    logic [4:0]  bin_high;
    logic [15:0] weight_high;
    logic        frame_last;
  } result_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/gob_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface gob_stream_if #(parameter int W = 16) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/gob_line_store.sv
// ----------------------------------------------------------------------------
// Line store
// Two lines of pixels, one read and one write per cycle, registered read.
// Each entry holds {top, mid} for one column.
// ----------------------------------------------------------------------------
module gob_line_store (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [gob_pkg::ColW-1:0] rd_addr,
  output logic [31:0]             rd_data,
  input  logic                    wr_en,
  input  logic [gob_pkg::ColW-1:0] wr_addr,
  input  logic [31:0]             wr_data
);
  logic [31:0] mem [gob_pkg::MaxWidth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

### rtl/core/gob_isqrt.sv
// ----------------------------------------------------------------------------
// Square root unit
// Bit-serial integer square root of a 32 bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module gob_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  logic [31:0] rem_r, rem_nxt;
  logic [15:0] res_r, res_nxt;
  logic [31:0] val_r, val_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] trial;
  logic [33:0] shifted;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r, val_r[31:30]};
    trial    = {16'd0, res_r, 2'b01};
    if (start) begin
      rem_nxt  = 32'd0;
      res_nxt  = 16'd0;
      val_nxt  = radicand;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[29:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt = 32'(shifted - trial);
        res_nxt = {res_r[14:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        res_nxt = {res_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    val_r <= val_nxt;
  end

  assign done = busy_r && (cnt_r == 5'd15);
  assign root = {res_r[14:0], (shifted >= trial)};
endmodule

### rtl/core/gradient_orientation_binner_core.sv
// ----------------------------------------------------------------------------
// Gradient orientation binner
// Flow: an interior pixel's accept passes through read, gradient, CORDIC (which
//   hides the bit-serial root) and bins to its result word.
// Throughput: one pixel at a time; the next pixel is accepted only after the
//   last one's result word is taken (border pixels give no result word).
// Reset: rst_n synchronous; col/row counters, window, config registers and
//   output valid to defaults; the line store is not cleared (unwritten entries read undefined).
// ----------------------------------------------------------------------------
module gradient_orientation_binner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_col,
  output logic [11:0] out_row,
  output logic [15:0] out_magnitude,
  output logic [15:0] out_direction,
  output logic [4:0]  out_bin_low,
  output logic [4:0]  out_bin_high,
  output logic [15:0] out_weight_high,
  output logic        out_frame_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int CW = gob_pkg::ColW;

  gob_stream_if #(16) in_if (clk);
  gob_stream_if #($bits(gob_pkg::result_t)) out_if (clk);
  assign in_if.valid = in_valid;
  assign in_if.data  = in_pixel;
  assign in_ready    = in_if.ready;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_READ = 6'b000010, S_GRAD = 6'b000100,
    S_CORD = 6'b001000, S_BIN  = 6'b010000, S_OUT  = 6'b100000
  } state_t;
  state_t state_r, state_nxt;

  logic [10:0] width_r;
  logic [11:0] height_r;
  logic        mode_r;
  logic [5:0]  bins_r;
  logic [31:0] noise_r;
  logic [10:0] col_r;
  logic [11:0] row_r;
  logic [15:0] win_r [6];
  logic [15:0] pix_r;
  logic [10:0] x_r;
  logic [11:0] y_r;
  logic [10:0] w_eff;
  logic [11:0] h_eff;
  logic [5:0]  nb_eff;
  logic [10:0] x_use;
  logic        accept;
  logic [31:0] rd_data;

  assign w_eff  = (width_r < 11'd3) ? 11'd3 :
                  (width_r > 11'(gob_pkg::MaxWidth)) ? 11'(gob_pkg::MaxWidth) : width_r;
  assign h_eff  = (height_r < 12'd3) ? 12'd3 : (height_r == 12'd4095) ? 12'd4095 : height_r;
  assign nb_eff = (bins_r == 6'd0) ? 6'd1 :
                  (bins_r > 6'(gob_pkg::MaxBins)) ? 6'(gob_pkg::MaxBins) : bins_r;
  assign x_use  = (col_r >= w_eff) ? 11'd0 : col_r;
  assign in_if.ready = (state_r == S_IDLE);
  assign accept = in_if.valid && in_if.ready;

  gob_line_store u_ls (
    .clk(clk), .rd_en(accept), .rd_addr(x_use[CW-1:0]), .rd_data(rd_data),
    .wr_en(state_r == S_READ), .wr_addr(x_r[CW-1:0]),
    .wr_data({rd_data[15:0], pix_r})
  );

  // rd_data: [31:16] top, [15:0] mid
  logic signed [19:0] gx_r, gy_r, gx_c, gy_c;
  logic [15:0] top_w, mid_w;
  assign top_w = rd_data[31:16];
  assign mid_w = rd_data[15:0];
  always_comb begin
    if (mode_r) begin
      gx_c = 20'sd0 + {4'd0, top_w} + {3'd0, mid_w, 1'b0} + {4'd0, pix_r}
             - {4'd0, win_r[0]} - {3'd0, win_r[1], 1'b0} - {4'd0, win_r[2]};
      gy_c = 20'sd0 + {4'd0, win_r[0]} + {3'd0, win_r[3], 1'b0} + {4'd0, top_w}
             - {4'd0, win_r[2]} - {3'd0, win_r[5], 1'b0} - {4'd0, pix_r};
    end else begin
      gx_c = ({4'd0, mid_w} - {4'd0, win_r[1]}) <<< 2;
      gy_c = ({4'd0, win_r[5]} - {4'd0, win_r[3]}) <<< 2;
    end
  end

  // squared magnitude, one multiply a cycle
  logic [39:0] sq_r;
  logic [40:0] s_sum;
  logic [38:0] thr;
  logic [31:0] rad;
  logic        sqrt_start, sqrt_done, mag_zero_r;
  logic [15:0] root;
  logic [15:0] mag_r;
  logic [1:0]  sq_ph_r;
  logic [19:0] ax;
  logic [19:0] ay;

  // CORDIC
  logic signed [35:0] cx_r, cy_r;
  logic [31:0] cz_r;
  logic [4:0]  it_r;
  logic        zero_r;
  logic signed [35:0] dx, dy;
  assign dx = cy_r >>> it_r;
  assign dy = cx_r >>> it_r;

  logic [15:0] dir_r;
  logic [27:0] t_full;
  logic [11:0] tq;
  logic [4:0]  blo;
  logic [4:0]  bhi;
  logic [5:0]  bsum;
  gob_pkg::result_t res_r;
  logic out_v_r;

  assign ax = gx_r[19] ? 20'(-gx_r) : gx_r;
  assign ay = gy_r[19] ? 20'(-gy_r) : gy_r;
  assign s_sum = 41'(sq_r) + 41'(40'(ay) * 40'(ay));
  assign thr = {noise_r, 6'd0} + 39'd0;
  assign rad = 32'((41'(sq_r) - 41'(thr)) >> 6);
  assign sqrt_start = (state_r == S_CORD) && (sq_ph_r == 2'd2);
  gob_isqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sqrt_start),
                    .radicand(mag_zero_r ? 32'd0 : rad), .done(sqrt_done), .root(root));

  assign t_full = 28'(nb_eff) * 28'(dir_r) * 28'd2;
  assign tq  = t_full[27:16];
  // tq < 2*nb; single compare-subtract gives the modulus
  assign blo = (tq >= 12'(nb_eff)) ? 5'(tq - 12'(nb_eff)) : 5'(tq);
  assign bsum = 6'(blo) + 6'd1;
  assign bhi = (bsum >= nb_eff) ? 5'(bsum - nb_eff) : 5'(bsum);

  logic sqrt_seen_r, cord_done;
  assign cord_done = (it_r == 5'(gob_pkg::CordicSteps));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_READ;
      S_READ: state_nxt = (x_r >= 11'd2 && y_r >= 12'd2) ? S_GRAD : S_IDLE;
      S_GRAD: state_nxt = S_CORD;
      S_CORD: if (cord_done && (sqrt_seen_r || sqrt_done)) state_nxt = S_BIN;
      S_BIN:  state_nxt = S_OUT;
      S_OUT:  if (!out_v_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      width_r  <= 11'd32;
      height_r <= 12'd32;
      mode_r   <= 1'b0;
      bins_r   <= 6'd8;
      noise_r  <= 32'd7730941;
      col_r    <= '0;
      row_r    <= '0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < 6; i++) win_r[i] <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (out_v_r && out_if.ready) out_v_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          gob_pkg::REG_WIDTH:  begin width_r <= cfg_data[10:0]; col_r <= '0; row_r <= '0; end
          gob_pkg::REG_HEIGHT: begin height_r <= cfg_data[11:0]; col_r <= '0; row_r <= '0; end
          gob_pkg::REG_MODE:   mode_r <= cfg_data[0];
          gob_pkg::REG_BINS:   bins_r <= cfg_data[5:0];
          gob_pkg::REG_NOISE:  noise_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        x_r <= x_use;
        y_r <= row_r;
        pix_r <= in_if.data;
        if (x_use + 11'd1 >= w_eff) begin
          col_r <= '0;
          row_r <= (row_r + 12'd1 >= h_eff) ? 12'd0 : row_r + 12'd1;
        end else begin
          col_r <= x_use + 11'd1;
        end
      end
      if (state_r == S_READ) begin
        gx_r <= gx_c;
        gy_r <= gy_c;
        win_r[0] <= win_r[3]; win_r[1] <= win_r[4]; win_r[2] <= win_r[5];
        win_r[3] <= top_w;    win_r[4] <= mid_w;    win_r[5] <= pix_r;
      end
      if (state_r == S_BIN) begin
        res_r.col         <= 10'(x_r - 11'd1);
        res_r.row         <= y_r - 12'd1;
        res_r.magnitude   <= mag_r;
        res_r.direction   <= dir_r;
        res_r.bin_low     <= blo;
        res_r.bin_high    <= bhi;
        res_r.weight_high <= t_full[15:0];
        res_r.frame_last  <= (x_r == w_eff - 11'd1) && (y_r == h_eff - 12'd1);
        out_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_GRAD) begin
      sq_ph_r <= 2'd0;
      sq_r <= 40'd0;
      sqrt_seen_r <= 1'b0;
      zero_r <= (gx_r == 20'sd0) && (gy_r == 20'sd0);
      cx_r <= 36'(gx_r[19] ? -gx_r : gx_r) <<< 12;
      cy_r <= 36'(gx_r[19] ? -gy_r : gy_r) <<< 12;
      cz_r <= gx_r[19] ? 32'h80000000 : 32'h0;
      it_r <= 5'd0;
    end else if (state_r == S_CORD) begin
      if (sq_ph_r == 2'd0) begin
        sq_r <= 40'(ax) * 40'(ax);
        sq_ph_r <= 2'd1;
      end else if (sq_ph_r == 2'd1) begin
        sq_r <= s_sum[39:0];
        mag_zero_r <= (s_sum <= 41'(thr));
        sq_ph_r <= 2'd2;
      end else if (sq_ph_r == 2'd2) begin
        sq_ph_r <= 2'd3;
      end
      if (sqrt_done) begin
        sqrt_seen_r <= 1'b1;
        mag_r <= mag_zero_r ? 16'd0 : root;
      end
      if (!cord_done) begin
        if (cy_r > 36'sd0) begin
          cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + gob_pkg::atan_turn(it_r);
        end else begin
          cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - gob_pkg::atan_turn(it_r);
        end
        it_r <= it_r + 5'd1;
      end else begin
        dir_r <= zero_r ? 16'd0 : 16'((cz_r + 32'd32768) >> 16);
      end
    end
  end

  assign out_if.valid = out_v_r;
  assign out_if.data  = res_r;
  assign out_if.ready = out_ready;
  assign out_valid       = out_if.valid;
  assign out_col         = res_r.col;
  assign out_row         = res_r.row;
  assign out_magnitude   = res_r.magnitude;
  assign out_direction   = res_r.direction;
  assign out_bin_low     = res_r.bin_low;
  assign out_bin_high    = res_r.bin_high;
  assign out_weight_high = res_r.weight_high;
  assign out_frame_last  = out_if.data[0];

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_v_r || state_r == S_IDLE)
    else $error("accepting while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r)
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CORD |-> !in_ready)
    else $error("accept during math");
endmodule
